// ----- src/double_byte_text_line_splitter_macros.svh -----
// Assertion macros shared by the line splitter RTL.
// Included by double_byte_text_line_splitter.sv; depends on nothing else.
`ifndef DOUBLE_BYTE_TEXT_LINE_SPLITTER_MACROS_SVH
`define DOUBLE_BYTE_TEXT_LINE_SPLITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBTLS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBTLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dbtls_pkg.sv -----
// Package for the double-byte text line splitter: sizes, character codes
// and the sequencer state type. Depends on nothing.
package dbtls_pkg;

    // Storage sizes.
    localparam int MAX_BYTES = 128;
    localparam int MAX_LINES = 16;

    // Buffer index, byte count, scan position and line counter widths.
    localparam int ADDR_W = $clog2(MAX_BYTES);
    localparam int CNT_W  = 8;
    localparam int POS_W  = CNT_W + 1;
    localparam int LINE_W = $clog2(MAX_LINES + 1);

    // Character codes.
    localparam logic [7:0] CHR_CR         = 8'h0d;
    localparam logic [7:0] CHR_LF         = 8'h0a;
    localparam logic [7:0] DBL_LEAD_ABOVE = 8'h80;

    // Line width after reset.
    localparam logic [7:0] WIDTH_RESET = 8'd16;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_LINE,
        S_FIT,
        S_FIT_CHK,
        S_NF_RD,
        S_NF_LEAD,
        S_NF_PAIR,
        S_END,
        S_EMIT
    } t_state;

endpackage

// ----- src/double_byte_text_line_splitter.sv -----
// Double-byte text line splitter: loads a message one byte per cycle (o_stall low),
// then scans it and emits one record per display line. After the byte marked last, each
// line is scanned one byte at a time (one two-byte character at a time when the rest is
// wider than the line), then its record is emitted once the output is not stalled.
// Synchronous active-low reset clears the sequencer, byte count and output valid and
// sets the line width to 16; the text buffer is not cleared.
module double_byte_text_line_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input byte channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_message_byte,
    input  logic       i_is_last_byte,
    // Line record channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_line_index,
    output logic [7:0] o_line_start,
    output logic [7:0] o_line_end,
    output logic       o_is_last_line,
    output logic       o_status,
    // Line width register write.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import dbtls_pkg::*;

    `include "double_byte_text_line_splitter_macros.svh"

    // Sequencer and datapath registers.
    t_state            r_state, n_state;
    logic [7:0]        r_width;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_p, n_p;
    logic [LINE_W-1:0] r_line, n_line;

    // Text buffer and its registered read data.
    logic [7:0]        mem [MAX_BYTES];
    logic [7:0]        r_rd0, r_rd1;
    logic              r_ok0, r_ok1;

    // Output record register.
    logic              r_o_valid;
    logic [3:0]        r_o_index;
    logic [7:0]        r_o_start, r_o_end;
    logic              r_o_last, r_o_status;

    // Control from the output decode.
    logic              w_we;
    logic              w_re;
    logic [POS_W-1:0]  w_ra;
    logic              w_emit;

    // Shared compare logic.
    logic [POS_W-1:0]  w_len, w_rem, w_d0, w_d2, w_wid;
    logic [7:0]        w_b0, w_b1;
    logic              w_pair, w_lead, w_fit, w_done, w_lastl, w_out_free;

    assign w_len   = POS_W'(r_count);
    assign w_wid   = POS_W'(r_width);
    assign w_rem   = w_len - r_pos;
    assign w_fit   = (w_rem <= w_wid);
    assign w_d0    = r_p - r_pos;
    assign w_d2    = r_p + POS_W'(2) - r_pos;
    assign w_b0    = r_ok0 ? r_rd0 : 8'h00;
    assign w_b1    = r_ok1 ? r_rd1 : 8'h00;
    assign w_pair  = (w_b0 == CHR_CR) && (w_b1 == CHR_LF);
    assign w_lead  = (w_b0 > DBL_LEAD_ABOVE);
    assign w_done  = (r_p >= w_len);
    assign w_lastl = w_done || (r_line == LINE_W'(MAX_LINES - 1));
    assign w_out_free = !r_o_valid || !i_stall;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid && i_is_last_byte) n_state = S_LINE;
            end
            S_LINE: begin
                n_state = w_fit ? S_FIT : S_NF_RD;
            end
            S_FIT: begin
                n_state = (r_p == w_len) ? S_END : S_FIT_CHK;
            end
            S_FIT_CHK: begin
                n_state = w_pair ? S_END : S_FIT;
            end
            S_NF_RD: begin
                n_state = S_NF_LEAD;
            end
            S_NF_LEAD: begin
                if (w_lead) begin
                    n_state = (w_d2 >= w_wid) ? S_END : S_NF_RD;
                end else begin
                    n_state = S_NF_PAIR;
                end
            end
            S_NF_PAIR: begin
                n_state = (w_pair || (w_d0 >= w_wid)) ? S_END : S_NF_LEAD;
            end
            S_END: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) n_state = w_lastl ? S_LOAD : S_LINE;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Sequencer outputs: input stall, buffer write and read, record load.
    always_comb begin
        o_stall = 1'b1;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_ra    = r_p;
        w_emit  = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_stall = 1'b0;
                w_we    = i_valid && (r_count < CNT_W'(MAX_BYTES));
            end
            S_FIT: begin
                w_re = (r_p != w_len);
                w_ra = r_p + POS_W'(1);
            end
            S_NF_RD: begin
                w_re = 1'b1;
            end
            S_NF_LEAD: begin
                w_re = !w_lead;
                w_ra = r_p + POS_W'(1);
            end
            S_END: begin
                w_re = 1'b1;
            end
            S_EMIT: begin
                w_emit = w_out_free;
            end
            S_LINE, S_FIT_CHK, S_NF_PAIR: begin
                w_re = 1'b0;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_p     = r_p;
        n_line  = r_line;
        case (r_state)
            S_LOAD: begin
                if (w_we) n_count = r_count + CNT_W'(1);
                if (i_valid && i_is_last_byte) begin
                    n_pos  = '0;
                    n_line = '0;
                end
            end
            S_LINE: begin
                n_p = r_pos;
            end
            S_FIT: begin
                if (r_p != w_len) n_p = r_p + POS_W'(1);
            end
            S_NF_LEAD: begin
                if (w_lead) begin
                    // A two-byte character that overshoots the width stays out.
                    if (!(w_d2 > w_wid)) n_p = r_p + POS_W'(2);
                end else begin
                    n_p = r_p + POS_W'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (w_lastl) begin
                        n_count = '0;
                    end else begin
                        n_pos  = w_pair ? (r_p + POS_W'(2)) : r_p;
                        n_line = r_line + LINE_W'(1);
                    end
                end
            end
            default: begin
                n_p = r_p;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_width   <= WIDTH_RESET;
            r_count   <= '0;
            r_pos     <= '0;
            r_p       <= '0;
            r_line    <= '0;
            r_ok0     <= 1'b0;
            r_ok1     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_p     <= n_p;
            r_line  <= n_line;
            if (i_cfg_valid) r_width <= i_cfg_data;
            if (w_re) begin
                r_ok0 <= (w_ra < w_len);
                r_ok1 <= ((w_ra + POS_W'(1)) < w_len);
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Text buffer: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_we) mem[r_count[ADDR_W-1:0]] <= i_message_byte;
        if (w_re) begin
            r_rd0 <= mem[w_ra[ADDR_W-1:0]];
            r_rd1 <= mem[ADDR_W'(w_ra + POS_W'(1))];
        end
    end

    // Output record payload.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_index  <= r_line[3:0];
            r_o_start  <= r_pos[7:0];
            r_o_end    <= r_p[7:0];
            r_o_last   <= w_lastl;
            r_o_status <= !w_done;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_line_index   = r_o_index;
    assign o_line_start   = r_o_start;
    assign o_line_end     = r_o_end;
    assign o_is_last_line = r_o_last;
    assign o_status       = r_o_status && r_o_last;
    assign o_cfg_ready    = 1'b1;

    // A line never ends before it starts.
    `DBTLS_ASSERT_SAME(a_end_after_start, i_clk, i_rst_n, o_valid, o_line_end >= o_line_start, "line end before line start")
    // Overflow status only appears on the final record.
    `DBTLS_ASSERT_SAME(a_status_last, i_clk, i_rst_n, o_valid && o_status, o_is_last_line, "status set on a record that is not last")
    // Emitting the final record empties the buffer for the next message.
    `DBTLS_ASSERT_NEXT(a_count_clear, i_clk, i_rst_n, w_emit && w_lastl, (r_count == '0) && (r_state == S_LOAD), "buffer not released after final record")

endmodule

// ----- sim/double_byte_text_line_splitter_tb.sv -----
// Self-checking testbench for double_byte_text_line_splitter: streams messages, predicts
// every line record from its own copy of the splitting rules and compares field by field.
// Depends on dbtls_pkg and the double_byte_text_line_splitter RTL.
module double_byte_text_line_splitter_tb;
    import dbtls_pkg::*;

    localparam int unsigned RUN_LIMIT = 400000;
    localparam int unsigned SETTLE    = 40;
    localparam int unsigned LONG_HOLD = 300;

    // One byte request on the input channel.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_msg;
    } t_byte_req;

    // One line record as the block reports it.
    typedef struct packed {
        logic [3:0] line_no;
        logic [7:0] start_ofs;
        logic [7:0] stop_ofs;
        logic       last_line;
        logic       status;
    } t_line_rec;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic       o_stall;
    logic [7:0] i_message_byte = 8'h00;
    logic       i_is_last_byte = 1'b0;
    logic       o_valid;
    logic       i_stall        = 1'b0;
    logic [3:0] o_line_index;
    logic [7:0] o_line_start;
    logic [7:0] o_line_end;
    logic       o_is_last_line;
    logic       o_status;
    logic       i_cfg_valid    = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data     = 8'h00;

    // Pending byte requests and the line records they are predicted to produce.
    t_byte_req   pending_bytes[$];
    t_line_rec   expected_lines[$];

    // Predictor state: the message collected so far and the active line width.
    logic [7:0]  text_mem[MAX_BYTES];
    int unsigned text_len    = 0;
    logic [7:0]  split_width = WIDTH_RESET;

    int unsigned errors       = 0;
    int unsigned bytes_sent   = 0;
    int unsigned cycle_count  = 0;
    bit          idle_on      = 1'b1;
    int unsigned holds_asked  = 0;
    int unsigned holds_given  = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned send_gap     = 0;

    double_byte_text_line_splitter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_byte (i_message_byte),
        .i_is_last_byte (i_is_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_line_index   (o_line_index),
        .o_line_start   (o_line_start),
        .o_line_end     (o_line_end),
        .o_is_last_line (o_is_last_line),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial forever #1 i_clk = ~i_clk;

    // Bytes beyond the stored message read as zero, which is neither CR nor LF.
    function automatic logic [7:0] text_at(int unsigned pos);
        return (pos < text_len) ? text_mem[pos] : 8'h00;
    endfunction

    function automatic bit crlf_at(int unsigned pos);
        return (text_at(pos) == CHR_CR) && (text_at(pos + 1) == CHR_LF);
    endfunction

    // Offset one past the last byte of the line that begins at start.
    function automatic int unsigned find_line_end(int unsigned start, int unsigned w);
        int unsigned p;
        int unsigned k;
        p = start;
        // The rest fits: only a CR LF pair past the first byte breaks it.
        if (text_len - start <= w) begin
            for (k = 0; k < text_len - start; k++) begin
                p++;
                if (crlf_at(p))
                    return p;
            end
            return p;
        end
        // Fill up to the width without splitting a two-byte character.
        forever begin
            if (text_at(p) > DBL_LEAD_ABOVE) begin
                p += 2;
                if (p - start == w)
                    return p;
                if (p - start > w)
                    return p - 2;
            end else begin
                p++;
                if (crlf_at(p))
                    return p;
                if (p - start >= w)
                    return p;
            end
        end
    endfunction

    // Store one accepted byte; on the final byte queue the whole set of line records.
    function automatic void take_message_byte(logic [7:0] b, logic fin);
        int unsigned start;
        int unsigned stop;
        int unsigned n;
        bit          done;
        t_line_rec   rec;
        if (text_len < MAX_BYTES) begin
            text_mem[text_len] = b;
            text_len++;
        end
        if (!fin)
            return;
        start = 0;
        done  = 1'b0;
        for (n = 0; n < MAX_LINES && !done; n++) begin
            stop          = find_line_end(start, split_width);
            rec.line_no   = n[3:0];
            rec.start_ofs = start[7:0];
            rec.stop_ofs  = stop[7:0];
            rec.last_line = 1'b0;
            rec.status    = 1'b0;
            if (stop >= text_len) begin
                done          = 1'b1;
                rec.last_line = 1'b1;
            end else if (n == MAX_LINES - 1) begin
                // Out of lines before the end of the message.
                rec.last_line = 1'b1;
                rec.status    = 1'b1;
            end
            expected_lines.push_back(rec);
            start = crlf_at(stop) ? stop + 2 : stop;
        end
        text_len = 0;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fin);
        t_byte_req req;
        req.text_byte  = b;
        req.end_of_msg = fin;
        pending_bytes.push_back(req);
        bytes_sent++;
    endtask

    // Queue one random message: text, two-byte characters, CR LF pairs and noise.
    task automatic queue_message(input int unsigned len);
        int unsigned k;
        int unsigned r;
        logic [7:0]  lead;
        logic [7:0]  trail;
        k = 0;
        while (k < len) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                push_byte(8'($urandom_range(8'h20, 8'h7e)), k + 1 == len);
                k++;
            end else if (r < 80) begin
                lead  = (r < 70) ? 8'($urandom_range(8'h81, 8'hff)) : CHR_CR;
                trail = (r < 70) ? 8'($urandom_range(8'h40, 8'hfe)) : CHR_LF;
                push_byte(lead, k + 1 == len);
                k++;
                if (k < len) begin
                    push_byte(trail, k + 1 == len);
                    k++;
                end
            end else if (r < 88) begin
                push_byte(($urandom_range(0, 1) != 0) ? CHR_CR : CHR_LF, k + 1 == len);
                k++;
            end else begin
                push_byte(8'($urandom_range(0, 255)), k + 1 == len);
                k++;
            end
        end
    endtask

    // Write the line width register; the block is idle whenever this is called.
    task automatic write_width(input logic [7:0] w);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        split_width = w;
        @(negedge i_clk);
    endtask

    // Wait until every request is taken and every predicted line has come back.
    task automatic wait_all_lines();
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_valid || expected_lines.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Sender: offers queued byte requests, with random gaps between them while idling is on.
    always @(posedge i_clk) begin : byte_sender
        t_byte_req nxt;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall)
                take_message_byte(i_message_byte, i_is_last_byte);
            if (!i_valid || !o_stall) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    i_valid        <= 1'b1;
                    i_message_byte <= nxt.text_byte;
                    i_is_last_byte <= nxt.end_of_msg;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 15);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random bursts while idling is on, plus a long hold whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_given != holds_asked) begin
            holds_given = holds_asked;
            i_stall   <= 1'b1;
            hold_left <= LONG_HOLD;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Check each accepted line record against the oldest prediction.
    always @(posedge i_clk) begin : line_checker
        t_line_rec got;
        t_line_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.line_no   = o_line_index;
            got.start_ofs = o_line_start;
            got.stop_ofs  = o_line_end;
            got.last_line = o_is_last_line;
            got.status    = o_status;
            if (expected_lines.size() == 0) begin
                if (errors < 10)
                    $display("unexpected line record: idx %0d start %0d end %0d last %b st %b",
                             got.line_no, got.start_ofs, got.stop_ofs, got.last_line,
                             got.status);
                errors++;
            end else begin
                want = expected_lines.pop_front();
                if (got !== want) begin
                    if (errors < 10)
                        $display({"line record mismatch: want idx %0d start %0d end %0d ",
                                  "last %b st %b, got idx %0d start %0d end %0d last %b st %b"},
                                 want.line_no, want.start_ofs, want.stop_ofs, want.last_line,
                                 want.status, got.line_no, got.start_ofs, got.stop_ofs,
                                 got.last_line, got.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("double_byte_text_line_splitter regression: fail");
            $finish;
        end
    end

    // Stimulus sequence: directed cases, a long receiver hold, random phases, then a closing phase.
    initial begin
        int unsigned ph;
        int unsigned r;
        int unsigned len;
        int unsigned nmsg;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset width: a one-byte message.
        @(negedge i_clk);
        push_byte(8'h41, 1'b1);
        wait_all_lines();

        // Width 1: a two-byte character never fits, so lines stall until the limit.
        write_width(8'd1);
        push_byte(8'h81, 1'b0);
        push_byte(8'h41, 1'b1);
        wait_all_lines();

        // Width 0: a single byte still makes a line, a two-byte character stalls.
        write_width(8'd0);
        push_byte(8'h61, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h40, 1'b1);
        wait_all_lines();

        // Widest setting: CR LF at the line start is kept, a trailing pair adds an
        // empty final line.
        write_width(8'd255);
        push_byte(CHR_CR, 1'b0);
        push_byte(CHR_LF, 1'b0);
        push_byte(8'h78, 1'b0);
        push_byte(CHR_CR, 1'b0);
        push_byte(CHR_LF, 1'b1);
        wait_all_lines();

        // Narrow width: a two-byte character straddling the limit, CR LF, 0x80 and zero.
        write_width(8'd4);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        push_byte(8'hb0, 1'b0);
        push_byte(8'ha1, 1'b0);
        push_byte(CHR_CR, 1'b0);
        push_byte(CHR_LF, 1'b0);
        push_byte(8'h64, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_all_lines();

        // Receiver holds off while a second message queues up behind the scan.
        write_width(8'd3);
        holds_asked++;
        repeat (2) queue_message($urandom_range(6, 8));
        wait_all_lines();

        // Random phases of short messages, each with its own width.
        ph = 0;
        while (bytes_sent < 50 && ph < 60) begin
            idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 19);
            if (r == 0)
                write_width(8'd255);
            else if (r == 1)
                write_width(8'd1);
            else if (r == 2)
                write_width(8'd2);
            else
                write_width(8'($urandom_range(3, 24)));
            nmsg = $urandom_range(1, 3);
            repeat (nmsg) begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    len = 1;
                else
                    len = $urandom_range(2, 16);
                queue_message(len);
            end
            wait_all_lines();
            ph++;
        end

        // Closing phase without any idling: an overlong message loses its extra bytes.
        idle_on = 1'b0;
        write_width(8'($urandom_range(5, 30)));
        queue_message($urandom_range(MAX_BYTES + 1, MAX_BYTES + 3));
        wait_all_lines();

        if (errors == 0 && expected_lines.size() == 0)
            $display("double_byte_text_line_splitter regression: pass");
        else
            $display("double_byte_text_line_splitter regression: fail");
        $finish;
    end

endmodule
